FILE: rtl/ffpa_pkg.sv
// shared constants, types and state codes for the first-fit page allocator
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;

  localparam int NUM_SLOTS  = 128;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);

  localparam int PAGE_W     = 20;
  localparam int REQ_PAGE_W = PAGE_W + 1;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;

  localparam logic [ADDR_W-1:0]     BASE_ADDR = 32'h0010_0000;
  localparam logic [SLOT_CNT_W-1:0] SLOT_FULL = SLOT_CNT_W'(NUM_SLOTS);

  localparam logic [STATUS_W-1:0] ALLOC_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ALLOC_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ALLOC_NO_SLOT = 2'd2;

  typedef struct packed {
    logic [PAGE_W-1:0] start_page;
    logic [PAGE_W-1:0] page_count;
    logic              is_free;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_WRF,
    S_DONE
  } alloc_state_t;

endpackage
`default_nettype wire

FILE: rtl/first_fit_page_allocator.sv
// first-fit page allocator top level: request fsm around the slot table ram
`timescale 1ns / 1ps
`default_nettype none
// steps: accept in S_IDLE, then S_SCAN over up to n slots (n = occupied slots, one
//   slot ram read per cycle), S_UPD (plus S_WRF on a split), S_DONE hands off to the output beat
// throughput: one request at a time
// reset: fsm idle, pool size 0, one occupied slot; slot 0 is served from registers until
//   first written, so the slot ram needs no clearing pass and a pool write takes effect at once
module first_fit_page_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [31:0]                    in_request_bytes,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [ffpa_pkg::ADDR_W-1:0]    out_block_address,
  output      logic [ffpa_pkg::STATUS_W-1:0]  out_alloc_status,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ffpa_pkg::PAGE_W-1:0]    cfg_pool_pages
);

  import ffpa_pkg::*;

  // control state
  alloc_state_t            state_r, state_nxt;
  logic [SLOT_CNT_W-1:0]   occ_cnt_r, occ_cnt_nxt;     // occupied slots form a prefix
  logic                    fresh_r, fresh_nxt;         // slot 0 still holds the pool
  logic [PAGE_W-1:0]       pool_r, pool_nxt;
  logic [SLOT_CNT_W-1:0]   scan_idx_r, scan_idx_nxt;   // next slot to read
  logic                    chk_vld_r, chk_vld_nxt;     // read data returning this cycle
  logic                    out_valid_r, out_valid_nxt;

  // payload
  logic [SLOT_IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [REQ_PAGE_W-1:0]   pages_r, pages_nxt;
  logic [SLOT_IDX_W-1:0]   fit_idx_r, fit_idx_nxt;
  slot_t                   fit_slot_r, fit_slot_nxt;
  logic [ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;

  // slot ram ports
  logic                    ram_wr_en;
  logic [SLOT_IDX_W-1:0]   ram_wr_addr;
  slot_t                   ram_wr_data;
  logic                    ram_rd_en;
  logic [SLOT_IDX_W-1:0]   ram_rd_addr;
  logic [SLOT_W-1:0]       ram_rd_data;

  // scan helpers
  logic                    issue;
  slot_t                   chk_slot;
  logic                    chk_hit;
  logic [REQ_PAGE_W-1:0]   req_pages;
  logic [ADDR_W-1:0]       fit_addr;

  ffpa_slot_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // round bytes up to whole pages, 21 bits so a request rounding up to 4 GiB still compares right
  assign req_pages = {1'b0, in_request_bytes[31:PAGE_SHIFT]}
                     + REQ_PAGE_W'(|in_request_bytes[PAGE_SHIFT-1:0]);

  // only the occupied prefix of the table is ever read
  assign issue       = (state_r == S_SCAN) && (scan_idx_r < occ_cnt_r);
  assign ram_rd_en   = issue;
  assign ram_rd_addr = scan_idx_r[SLOT_IDX_W-1:0];

  // slot 0 comes from registers until slot 0 is first written after a restart
  always_comb begin
    if (fresh_r && (chk_idx_r == '0)) begin
      chk_slot.start_page = '0;
      chk_slot.page_count = pool_r;
      chk_slot.is_free    = 1'b1;
    end else begin
      chk_slot = slot_t'(ram_rd_data);
    end
  end

  assign chk_hit  = chk_vld_r && chk_slot.is_free && ({1'b0, chk_slot.page_count} >= pages_r);
  assign fit_addr = BASE_ADDR + {fit_slot_r.start_page, PAGE_SHIFT'(0)};

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_alloc_status  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_cnt_r   <= SLOT_CNT_W'(1);
      fresh_r     <= 1'b1;
      pool_r      <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_cnt_r   <= occ_cnt_nxt;
      fresh_r     <= fresh_nxt;
      pool_r      <= pool_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    pages_r      <= pages_nxt;
    fit_idx_r    <= fit_idx_nxt;
    fit_slot_r   <= fit_slot_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    occ_cnt_nxt    = occ_cnt_r;
    fresh_nxt      = fresh_r;
    pool_nxt       = pool_r;
    scan_idx_nxt   = scan_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    pages_nxt      = pages_r;
    fit_idx_nxt    = fit_idx_r;
    fit_slot_nxt   = fit_slot_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = fit_idx_r;
    ram_wr_data    = fit_slot_r;

    // output beat taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // pool write restarts the table; the user must write it only while idle, the block does not enforce this
    if (cfg_wr_en) begin
      pool_nxt    = cfg_pool_pages;
      fresh_nxt   = 1'b1;
      occ_cnt_nxt = SLOT_CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pages_nxt    = req_pages;
          scan_idx_nxt = '0;
          if (req_pages == '0) begin
            // zero-byte request never creates a region
            res_addr_nxt   = '0;
            res_status_nxt = ALLOC_NO_FIT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = scan_idx_r[SLOT_IDX_W-1:0];
        if (issue) begin
          scan_idx_nxt = scan_idx_r + SLOT_CNT_W'(1);
        end
        if (chk_hit) begin
          fit_idx_nxt  = chk_idx_r;
          fit_slot_nxt = chk_slot;
          chk_vld_nxt  = 1'b0;
          state_nxt    = S_UPD;
        end else if (!issue && !chk_vld_r) begin
          // whole prefix checked, nothing large enough
          res_addr_nxt   = '0;
          res_status_nxt = ALLOC_NO_FIT;
          state_nxt      = S_DONE;
        end
      end
      S_UPD: begin
        if ({1'b0, fit_slot_r.page_count} == pages_r) begin
          // exact fit
          ram_wr_en           = 1'b1;
          ram_wr_addr         = fit_idx_r;
          ram_wr_data.is_free = 1'b0;
          if (fit_idx_r == '0) begin
            fresh_nxt = 1'b0;
          end
          res_addr_nxt   = fit_addr;
          res_status_nxt = ALLOC_OK;
          state_nxt      = S_DONE;
        end else if (occ_cnt_r == SLOT_FULL) begin
          res_addr_nxt   = '0;
          res_status_nxt = ALLOC_NO_SLOT;
          state_nxt      = S_DONE;
        end else begin
          // tail goes to the first unused slot, the end of the prefix
          ram_wr_en              = 1'b1;
          ram_wr_addr            = occ_cnt_r[SLOT_IDX_W-1:0];
          ram_wr_data.start_page = fit_slot_r.start_page + pages_r[PAGE_W-1:0];
          ram_wr_data.page_count = fit_slot_r.page_count - pages_r[PAGE_W-1:0];
          ram_wr_data.is_free    = 1'b1;
          occ_cnt_nxt            = occ_cnt_r + SLOT_CNT_W'(1);
          state_nxt              = S_WRF;
        end
      end
      S_WRF: begin
        // front part of the split region
        ram_wr_en              = 1'b1;
        ram_wr_addr            = fit_idx_r;
        ram_wr_data.page_count = pages_r[PAGE_W-1:0];
        ram_wr_data.is_free    = 1'b0;
        if (fit_idx_r == '0) begin
          fresh_nxt = 1'b0;
        end
        res_addr_nxt   = fit_addr;
        res_status_nxt = ALLOC_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // occupied count stays within the table and never empties
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_cnt_r != '0) && (occ_cnt_r <= SLOT_FULL))
    else $error("occupied slot count out of range");

  // occupied count grows by at most one per cycle outside a pool write
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> (occ_cnt_r == $past(occ_cnt_r))
                   || (occ_cnt_r == $past(occ_cnt_r) + SLOT_CNT_W'(1)))
    else $error("occupied slot count jumped");

  // returning read data always belongs to an occupied slot
  a_chk_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> ({1'b0, chk_idx_r} < occ_cnt_r))
    else $error("scan read beyond occupied slots");

  // table writes happen only in the update states
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ((state_r == S_UPD) || (state_r == S_WRF)))
    else $error("slot ram write outside update");

  // the split's second write always follows the tail write
  a_wrf_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRF) |-> ($past(state_r) == S_UPD))
    else $error("fit write without preceding split");
`endif

endmodule
`default_nettype wire

FILE: rtl/ffpa_slot_ram.sv
// slot table ram: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none
module ffpa_slot_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
